// ===== hw/rtl/vertex_affine_transform_unit_macros.svh =====
// Assertion helpers used by the checker file vat_checker.sv.
`ifndef VERTEX_AFFINE_TRANSFORM_UNIT_MACROS_SVH
`define VERTEX_AFFINE_TRANSFORM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define VAT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vertex transform check failed");

// Next-cycle implication, disabled while reset is low.
`define VAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vertex transform check failed");

`endif

// ===== hw/rtl/vat_pkg.sv =====
`timescale 1ns / 1ps

package vat_pkg;

	localparam int COORD_W             = 32;
	localparam int COEFF_W             = 16;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int TRIG_FRAC_BITS      = 14;
	localparam int NUM_LANES           = 3;
	localparam int CFG_IDX_W           = 3;
	// multiplier operands and products
	localparam int F2_W    = COEFF_W + 1;
	localparam int PROD1_W = 2 * COORD_W;
	localparam int PROD2_W = COORD_W + F2_W;
	localparam int SUM_W   = PROD1_W + 2;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
	localparam logic signed [COORD_W-1:0] SCALE_ONE_DEF = 32'sh00010000;
	localparam logic signed [COEFF_W-1:0] COS_RST = 16'sh4000;

	typedef enum logic [2:0] {
		MODE_TRANSLATE = 3'd0,
		MODE_SCALE_AXIS = 3'd1,
		MODE_SCALE_ALL = 3'd2,
		MODE_ROT_X = 3'd3,
		MODE_ROT_Y = 3'd4,
		MODE_ROT_Z = 3'd5
	} vat_mode_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} vat_axis_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 3'd0,
		REG_AXIS = 3'd1,
		REG_OFFSET = 3'd2,
		REG_SCALE = 3'd3,
		REG_COS = 3'd4,
		REG_SIN = 3'd5
	} vat_reg_t;

	// which rounding shift a lane applies after the sum
	typedef enum logic [1:0] {
		SH_NONE,
		SH_COORD,
		SH_TRIG
	} vat_shift_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_in;
		logic signed [COORD_W-1:0] y_in;
		logic signed [COORD_W-1:0] z_in;
		logic                      last_in;
	} vat_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
		logic signed [COORD_W-1:0] z_out;
		logic                      last_out;
		logic                      saturated;
	} vat_out_t;

	// lane result = (a1*f1 + a2*f2) rounded and shifted
	typedef struct packed {
		logic signed [COORD_W-1:0] a1;
		logic signed [COORD_W-1:0] f1;
		logic signed [COORD_W-1:0] a2;
		logic signed [F2_W-1:0]    f2;
		vat_shift_t                sh;
	} vat_opnd_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} vat_adv_t;

	typedef struct packed {
		logic [2:0]                mode;
		logic [1:0]                axis;
		logic signed [COORD_W-1:0] offset;
		logic signed [COORD_W-1:0] scale_factor;
		logic signed [COEFF_W-1:0] cos_coeff;
		logic signed [COEFF_W-1:0] sin_coeff;
	} vat_cfg_t;

endpackage

// ===== hw/rtl/vat_operand_sel.sv =====
`timescale 1ns / 1ps

module vat_operand_sel import vat_pkg::*; (
	input  logic      clk,
	input  vat_cfg_t  cfg,
	input  vat_adv_t  adv,
	input  vat_in_t   vertex,
	output vat_opnd_t opnd_s1 [NUM_LANES]
);

	logic signed [COORD_W-1:0] v [NUM_LANES];
	vat_opnd_t                 opnd [NUM_LANES];
	logic [1:0]                ax;
	logic [1:0]                p;
	logic [1:0]                q;
	logic                      rot_en;
	logic signed [COORD_W-1:0] c_ext;
	logic signed [F2_W-1:0]    s_ext;

	assign v[0] = vertex.x_in;
	assign v[1] = vertex.y_in;
	assign v[2] = vertex.z_in;

	// axis code three falls to z
	assign ax = (cfg.axis == AXIS_X) ? AXIS_X : (cfg.axis == AXIS_Y) ? AXIS_Y : AXIS_Z;
	assign c_ext = COORD_W'(cfg.cos_coeff);
	assign s_ext = F2_W'(cfg.sin_coeff);

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			opnd[i].a1 = v[i];
			opnd[i].f1 = COORD_W'(1);
			opnd[i].a2 = '0;
			opnd[i].f2 = '0;
			opnd[i].sh = SH_NONE;
		end
		rot_en = 1'b0;
		p = AXIS_X;
		q = AXIS_Y;
		case (cfg.mode)
			MODE_TRANSLATE: begin
				opnd[ax].a2 = cfg.offset;
				opnd[ax].f2 = F2_W'(1);
			end
			MODE_SCALE_AXIS: begin
				opnd[ax].f1 = cfg.scale_factor;
				opnd[ax].sh = SH_COORD;
			end
			MODE_SCALE_ALL: begin
				for (int i = 0; i < NUM_LANES; i++) begin
					opnd[i].f1 = cfg.scale_factor;
					opnd[i].sh = SH_COORD;
				end
			end
			MODE_ROT_X: begin
				rot_en = 1'b1;
				p = AXIS_Y;
				q = AXIS_Z;
			end
			MODE_ROT_Y: begin
				rot_en = 1'b1;
				p = AXIS_X;
				q = AXIS_Z;
			end
			MODE_ROT_Z: begin
				rot_en = 1'b1;
				p = AXIS_X;
				q = AXIS_Y;
			end
			default: ;
		endcase
		// p' = p*c + q*s, q' = q*c - p*s
		if (rot_en) begin
			opnd[p].a1 = v[p];
			opnd[p].f1 = c_ext;
			opnd[p].a2 = v[q];
			opnd[p].f2 = s_ext;
			opnd[p].sh = SH_TRIG;
			opnd[q].a1 = v[q];
			opnd[q].f1 = c_ext;
			opnd[q].a2 = v[p];
			opnd[q].f2 = -s_ext;
			opnd[q].sh = SH_TRIG;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			opnd_s1 <= opnd;
		end
	end

endmodule

// ===== hw/rtl/vat_lane.sv =====
`timescale 1ns / 1ps

module vat_lane import vat_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  vat_adv_t                  adv,
	input  vat_opnd_t                 opnd_s1,
	output logic signed [COORD_W-1:0] coord_s4,
	output logic                      sat_s4
);

	// half an output LSB; zero when there is no shift
	localparam logic signed [SUM_W-1:0] RND_COORD = (SUM_W'(1) << COORD_FRAC_BITS) >> 1;
	localparam logic signed [SUM_W-1:0] RND_TRIG = SUM_W'(1) << (TRIG_FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] LIM_MAX = SUM_W'(COORD_MAX);
	localparam logic signed [SUM_W-1:0] LIM_MIN = SUM_W'(COORD_MIN);

	logic signed [PROD1_W-1:0] p1_s2;
	logic signed [PROD2_W-1:0] p2_s2;
	vat_shift_t                sh_s2;
	logic signed [SUM_W-1:0]   sum_s3;
	vat_shift_t                sh_s3;
	logic signed [SUM_W-1:0]   rnd;
	logic signed [SUM_W-1:0]   shifted;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p1_s2 <= opnd_s1.a1 * opnd_s1.f1;
			p2_s2 <= PROD2_W'(opnd_s1.a2) * PROD2_W'(opnd_s1.f2);
			sh_s2 <= opnd_s1.sh;
		end
	end

	always_comb begin
		case (sh_s2)
			SH_COORD: rnd = RND_COORD;
			SH_TRIG:  rnd = RND_TRIG;
			default:  rnd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sum_s3 <= SUM_W'(p1_s2) + SUM_W'(p2_s2) + rnd;
			sh_s3  <= sh_s2;
		end
	end

	always_comb begin
		case (sh_s3)
			SH_COORD: shifted = sum_s3 >>> COORD_FRAC_BITS;
			SH_TRIG:  shifted = sum_s3 >>> TRIG_FRAC_BITS;
			default:  shifted = sum_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			if (shifted > LIM_MAX) begin
				coord_s4 <= COORD_MAX;
				sat_s4   <= 1'b1;
			end else if (shifted < LIM_MIN) begin
				coord_s4 <= COORD_MIN;
				sat_s4   <= 1'b1;
			end else begin
				coord_s4 <= shifted[COORD_W-1:0];
				sat_s4   <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/vertex_affine_transform_unit.sv =====
`timescale 1ns / 1ps

// Affine transform of a stream of Q16.16 vertices: translate or scale one axis,
// scale all axes, or rotate about x, y or z with loaded Q2.14 cosine and sine,
// every result clamped to 32 bits and flagged when clamped. Four register stages
// (operand select, multiply, sum and round, shift and clamp) lie between an
// accepted vertex beat and its result beat, and one vertex is taken every cycle
// while the result side keeps up; the stage-four register is the output, and a
// stall backs up one stage at a time so bubbles are squeezed out. Write the
// configuration registers only while no vertex is in flight.
module vertex_affine_transform_unit import vat_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata,
	input  logic                 vertex_valid,
	output logic                 vertex_ready,
	input  vat_in_t              vertex,
	output logic                 result_valid,
	input  logic                 result_ready,
	output vat_out_t             result
);

	vat_cfg_t                  cfg_q;
	vat_adv_t                  adv;
	vat_opnd_t                 opnd_s1 [NUM_LANES];
	logic signed [COORD_W-1:0] coord_s4 [NUM_LANES];
	logic [NUM_LANES-1:0]      sat_s4;
	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic                      last_s1, last_s2, last_s3, last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_TRANSLATE;
			cfg_q.axis         <= AXIS_X;
			cfg_q.offset       <= '0;
			cfg_q.scale_factor <= COORD_W'(64'd1 << COORD_FRAC_BITS);
			cfg_q.cos_coeff    <= COS_RST;
			cfg_q.sin_coeff    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode         <= cfg_wdata[2:0];
				REG_AXIS:   cfg_q.axis         <= cfg_wdata[1:0];
				REG_OFFSET: cfg_q.offset       <= cfg_wdata;
				REG_SCALE:  cfg_q.scale_factor <= cfg_wdata;
				REG_COS:    cfg_q.cos_coeff    <= cfg_wdata[COEFF_W-1:0];
				REG_SIN:    cfg_q.sin_coeff    <= cfg_wdata[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the next one takes its beat
	assign adv.s4 = !valid_s4 || result_ready;
	assign adv.s3 = !valid_s3 || adv.s4;
	assign adv.s2 = !valid_s2 || adv.s3;
	assign adv.s1 = !valid_s1 || adv.s2;
	assign vertex_ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv.s1) valid_s1 <= vertex_valid;
			if (adv.s2) valid_s2 <= valid_s1;
			if (adv.s3) valid_s3 <= valid_s2;
			if (adv.s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) last_s1 <= vertex.last_in;
		if (adv.s2) last_s2 <= last_s1;
		if (adv.s3) last_s3 <= last_s2;
		if (adv.s4) last_s4 <= last_s3;
	end

	vat_operand_sel u_sel (
		.clk     (clk),
		.cfg     (cfg_q),
		.adv     (adv),
		.vertex  (vertex),
		.opnd_s1 (opnd_s1)
	);

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		vat_lane #(
			.COORD_FRAC_BITS (COORD_FRAC_BITS)
		) u_lane (
			.clk      (clk),
			.adv      (adv),
			.opnd_s1  (opnd_s1[g]),
			.coord_s4 (coord_s4[g]),
			.sat_s4   (sat_s4[g])
		);
	end

	assign result_valid       = valid_s4;
	assign result.x_out       = coord_s4[0];
	assign result.y_out       = coord_s4[1];
	assign result.z_out       = coord_s4[2];
	assign result.last_out    = last_s4;
	assign result.saturated   = |sat_s4;

endmodule

// ===== hw/rtl/vat_checker.sv =====
`timescale 1ns / 1ps

`include "vertex_affine_transform_unit_macros.svh"

module vat_checker import vat_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     vertex_valid,
	input logic     vertex_ready,
	input vat_in_t  vertex,
	input logic     result_valid,
	input logic     result_ready,
	input vat_out_t result
);

	logic [2:0] occ_q;
	logic       in_beat;
	logic       out_beat;
	logic       clamp_seen;

	assign in_beat  = vertex_valid && vertex_ready;
	assign out_beat = result_valid && result_ready;
	assign clamp_seen = result.x_out == COORD_MAX || result.x_out == COORD_MIN
		|| result.y_out == COORD_MAX || result.y_out == COORD_MIN
		|| result.z_out == COORD_MAX || result.z_out == COORD_MIN;

	// vertices inside the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	`VAT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
	`VAT_ASSERT_NOW(a_no_phantom, result_valid, occ_q != 3'd0)
	`VAT_ASSERT_NOW(a_depth, 1'b1, occ_q <= 3'd4)
	`VAT_ASSERT_NOW(a_full_rate, result_ready, vertex_ready)
	`VAT_ASSERT_NOW(a_sat_clamped, result_valid && result.saturated, clamp_seen)

endmodule

bind vertex_affine_transform_unit vat_checker u_vat_checker (.*);
